/* design/tafa_pkg.sv */
// ----------------------------------------------------------------------------
// tafa_pkg: shared types and constants for the accelerometer tilt angle block
// Number formats, pipeline widths, selector codes and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package tafa_pkg;

    // Sample and result formats
    localparam int SAMPLE_WIDTH    = 16;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int OUT_W           = 15;

    // Square root: radicand is a*a + b*b followed by 32 zero bits
    localparam int SQ_RAD_W = 2 * SAMPLE_WIDTH;
    localparam int ROOT_W   = SAMPLE_WIDTH + 16;
    localparam int REM_W    = ROOT_W + 2;

    // CORDIC datapath: root has 16 fraction bits, both operands get 30
    localparam int X_SH     = 14;
    localparam int Y_SH     = 30;
    localparam int XY_W     = ROOT_W + X_SH + 4;
    localparam int STAGES   = 26;
    localparam int STG_IW   = $clog2(STAGES);

    // Angle accumulator in degrees with 20 fraction bits
    localparam int ACC_FRAC   = 20;
    localparam int ZW         = 29;
    localparam int ROUND_SH   = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(1 << (ROUND_SH - 1));
    localparam logic signed [ZW-1:0] ANGLE_LIM  = ZW'(90 << ANGLE_FRAC_BITS);

    // Selector codes
    localparam logic [1:0] FUNC_ROLL  = 2'd0;
    localparam logic [1:0] FUNC_PITCH = 2'd1;

    // Per-stage control: occupancy and forced-zero result
    typedef struct packed {
        logic valid;
        logic zero;
    } t_ctrl;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [XY_W-1:0]         t_xy;
    typedef logic signed [ZW-1:0]           t_ang;

    // atan(2^-i) in degrees, scaled by 2^20
    function automatic t_ang atan_deg(input logic [STG_IW-1:0] idx);
        t_ang val;
        case (idx)
            5'd0:    val = ZW'(47185920);
            5'd1:    val = ZW'(27855475);
            5'd2:    val = ZW'(14718068);
            5'd3:    val = ZW'(7471121);
            5'd4:    val = ZW'(3750058);
            5'd5:    val = ZW'(1876857);
            5'd6:    val = ZW'(938658);
            5'd7:    val = ZW'(469357);
            5'd8:    val = ZW'(234682);
            5'd9:    val = ZW'(117342);
            5'd10:   val = ZW'(58671);
            5'd11:   val = ZW'(29335);
            5'd12:   val = ZW'(14668);
            5'd13:   val = ZW'(7334);
            5'd14:   val = ZW'(3667);
            5'd15:   val = ZW'(1833);
            5'd16:   val = ZW'(917);
            5'd17:   val = ZW'(458);
            5'd18:   val = ZW'(229);
            5'd19:   val = ZW'(115);
            5'd20:   val = ZW'(57);
            5'd21:   val = ZW'(29);
            5'd22:   val = ZW'(14);
            5'd23:   val = ZW'(7);
            5'd24:   val = ZW'(4);
            5'd25:   val = ZW'(2);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

/* design/tafa_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// tafa_sqrt_cell: one digit step of the pipelined integer square root
// Brings down two radicand bits, tries 4*root+1 and retires one root bit.
// ----------------------------------------------------------------------------
`default_nettype none

module tafa_sqrt_cell (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_en,
    input  wire tafa_pkg::t_ctrl            i_ctrl,
    input  wire tafa_pkg::t_sample          i_num,
    input  wire [tafa_pkg::SQ_RAD_W-1:0]    i_rad,
    input  wire [tafa_pkg::REM_W-1:0]       i_rem,
    input  wire [tafa_pkg::ROOT_W-1:0]      i_root,
    output tafa_pkg::t_ctrl                 o_ctrl,
    output tafa_pkg::t_sample               o_num,
    output logic [tafa_pkg::SQ_RAD_W-1:0]   o_rad,
    output logic [tafa_pkg::REM_W-1:0]      o_rem,
    output logic [tafa_pkg::ROOT_W-1:0]     o_root
);
    import tafa_pkg::*;

    logic [REM_W+1:0]    cur;
    logic [REM_W+1:0]    trial;
    logic [REM_W+1:0]    diff;
    logic [REM_W-1:0]    n_rem;
    logic [ROOT_W-1:0]   n_root;
    t_ctrl               r_ctrl;
    t_sample             r_num;
    logic [SQ_RAD_W-1:0] r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;

    // Trial subtraction; remainder never exceeds 2*root so it fits REM_W
    assign cur   = {i_rem, i_rad[SQ_RAD_W-1 -: 2]};
    assign trial = {2'b00, i_root, 2'b01};
    assign diff  = cur - trial;

    always_comb begin
        if (cur >= trial) begin
            n_rem  = diff[REM_W-1:0];
            n_root = {i_root[ROOT_W-2:0], 1'b1};
        end else begin
            n_rem  = cur[REM_W-1:0];
            n_root = {i_root[ROOT_W-2:0], 1'b0};
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= i_num;
            r_rad  <= {i_rad[SQ_RAD_W-3:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_num  = r_num;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

`default_nettype wire

/* design/tafa_cordic_cell.sv */
// ----------------------------------------------------------------------------
// tafa_cordic_cell: one vectoring-mode CORDIC micro-rotation
// Rotates (x, y) toward the x axis and accumulates the angle in degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module tafa_cordic_cell (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_en,
    input  wire [tafa_pkg::STG_IW-1:0]    i_stage,
    input  wire tafa_pkg::t_ctrl          i_ctrl,
    input  wire tafa_pkg::t_xy            i_x,
    input  wire tafa_pkg::t_xy            i_y,
    input  wire tafa_pkg::t_ang           i_z,
    output tafa_pkg::t_ctrl               o_ctrl,
    output tafa_pkg::t_xy                 o_x,
    output tafa_pkg::t_xy                 o_y,
    output tafa_pkg::t_ang                o_z
);
    import tafa_pkg::*;

    t_xy   xs;
    t_xy   ys;
    t_ang  at;
    t_xy   n_x;
    t_xy   n_y;
    t_ang  n_z;
    t_ctrl r_ctrl;
    t_xy   r_x;
    t_xy   r_y;
    t_ang  r_z;

    // Floor shifts by the stage index, stage angle from the table
    assign xs = i_x >>> i_stage;
    assign ys = i_y >>> i_stage;
    assign at = atan_deg(i_stage);

    // Rotate against the sign of y (zero counts as positive)
    always_comb begin
        if (!i_y[XY_W-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + at;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - at;
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

`default_nettype wire

/* design/tilt_angle_from_accel.sv */
// ----------------------------------------------------------------------------
// tilt_angle_from_accel: roll or negated pitch from one accelerometer sample
// Squares, a digit-serial square root chain and a CORDIC chain, fully pipelined.
// ----------------------------------------------------------------------------
// One transaction per clock is taken while o_stall is low, and one angle
// comes out per transaction, in order. Each result passes through the 62
// register stages of the cell chains: three front stages (operand select,
// squares, sum), 32 square root cells (one root bit each), 26 CORDIC cells
// and the output register. The whole pipeline advances together; a result
// that meets a stalled output goes to a one-entry skid register, and
// o_stall is raised while that register is full. Func 0 gives roll, 1 the
// negated pitch, 2 and 3 give zero, as does a zero numerator sample.
`default_nettype none

module tilt_angle_from_accel (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_stall,
    input  wire signed [15:0]             i_accel_x,
    input  wire signed [15:0]             i_accel_y,
    input  wire signed [15:0]             i_accel_z,
    input  wire [1:0]                     i_func,
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic signed [tafa_pkg::OUT_W-1:0] o_angle
);
    import tafa_pkg::*;

    logic                 adv;
    t_sample              sx, sy, sz;
    t_sample              sel_num, sel_a, sel_b;
    logic                 sel_zero;

    t_ctrl                r_a_ctrl;
    t_sample              r_a_num, r_a_opa, r_a_opb;
    t_ctrl                r_b_ctrl;
    t_sample              r_b_num;
    logic [SQ_RAD_W-1:0]  r_b_sqa, r_b_sqb;
    t_ctrl                r_c_ctrl;
    t_sample              r_c_num;
    logic [SQ_RAD_W-1:0]  r_c_sum;

    t_ctrl                sq_ctrl [0:ROOT_W];
    t_sample              sq_num  [0:ROOT_W];
    logic [SQ_RAD_W-1:0]  sq_rad  [0:ROOT_W];
    logic [REM_W-1:0]     sq_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]    sq_root [0:ROOT_W];

    t_ctrl                cd_ctrl [0:STAGES];
    t_xy                  cd_x    [0:STAGES];
    t_xy                  cd_y    [0:STAGES];
    t_ang                 cd_z    [0:STAGES];

    t_ang                 z_rnd;
    t_ang                 z_q;
    t_ang                 z_clamp;
    logic [OUT_W-1:0]     final_angle;
    logic                 final_valid;

    logic                 r_out_valid;
    logic                 r_skid_valid;
    logic [OUT_W-1:0]     r_out_angle;
    logic [OUT_W-1:0]     r_skid_angle;

    // Pipeline moves whenever the skid register is free
    assign adv     = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // Operand select
    assign sx = i_accel_x[SAMPLE_WIDTH-1:0];
    assign sy = i_accel_y[SAMPLE_WIDTH-1:0];
    assign sz = i_accel_z[SAMPLE_WIDTH-1:0];

    always_comb begin
        sel_a = sy;
        sel_b = sz;
        case (i_func)
            FUNC_ROLL: begin
                sel_num  = sy;
                sel_a    = sx;
                sel_zero = (sy == '0);
            end
            FUNC_PITCH: begin
                sel_num  = sx;
                sel_zero = (sx == '0);
            end
            default: begin
                sel_num  = sx;
                sel_zero = 1'b1;
            end
        endcase
    end

    // Front stages: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctrl <= '0;
            r_b_ctrl <= '0;
            r_c_ctrl <= '0;
        end else if (adv) begin
            r_a_ctrl <= '{valid: i_valid, zero: sel_zero};
            r_b_ctrl <= r_a_ctrl;
            r_c_ctrl <= r_b_ctrl;
        end
    end

    // Front stages: select, square (full-width products), sum
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_num <= sel_num;
            r_a_opa <= sel_a;
            r_a_opb <= sel_b;
            r_b_num <= r_a_num;
            r_b_sqa <= $unsigned(SQ_RAD_W'(r_a_opa) * SQ_RAD_W'(r_a_opa));
            r_b_sqb <= $unsigned(SQ_RAD_W'(r_a_opb) * SQ_RAD_W'(r_a_opb));
            r_c_num <= r_b_num;
            r_c_sum <= r_b_sqa + r_b_sqb;
        end
    end

    // Square root chain: floor(sqrt(sum * 2^32))
    assign sq_ctrl[0] = r_c_ctrl;
    assign sq_num[0]  = r_c_num;
    assign sq_rad[0]  = r_c_sum;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    genvar g;
    for (g = 0; g < ROOT_W; g++) begin : g_sqrt
        tafa_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_ctrl  (sq_ctrl[g]),
            .i_num   (sq_num[g]),
            .i_rad   (sq_rad[g]),
            .i_rem   (sq_rem[g]),
            .i_root  (sq_root[g]),
            .o_ctrl  (sq_ctrl[g+1]),
            .o_num   (sq_num[g+1]),
            .o_rad   (sq_rad[g+1]),
            .o_rem   (sq_rem[g+1]),
            .o_root  (sq_root[g+1])
        );
    end

    // CORDIC chain: both operands aligned to 30 fraction bits
    assign cd_ctrl[0] = sq_ctrl[ROOT_W];
    assign cd_x[0]    = $signed({{(XY_W-ROOT_W-X_SH){1'b0}}, sq_root[ROOT_W], {X_SH{1'b0}}});
    assign cd_y[0]    = $signed({{(XY_W-SAMPLE_WIDTH-Y_SH){sq_num[ROOT_W][SAMPLE_WIDTH-1]}},
                                 sq_num[ROOT_W], {Y_SH{1'b0}}});
    assign cd_z[0]    = '0;

    for (g = 0; g < STAGES; g++) begin : g_cordic
        tafa_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_stage (STG_IW'(g)),
            .i_ctrl  (cd_ctrl[g]),
            .i_x     (cd_x[g]),
            .i_y     (cd_y[g]),
            .i_z     (cd_z[g]),
            .o_ctrl  (cd_ctrl[g+1]),
            .o_x     (cd_x[g+1]),
            .o_y     (cd_y[g+1]),
            .o_z     (cd_z[g+1])
        );
    end

    // Round to nearest output step, clamp to +-90 degrees
    assign z_rnd = cd_z[STAGES] + ROUND_HALF;
    assign z_q   = z_rnd >>> ROUND_SH;

    always_comb begin
        if (z_q > ANGLE_LIM) begin
            z_clamp = ANGLE_LIM;
        end else if (z_q < -ANGLE_LIM) begin
            z_clamp = -ANGLE_LIM;
        end else begin
            z_clamp = z_q;
        end
    end

    assign final_angle = cd_ctrl[STAGES].zero ? '0 : z_clamp[OUT_W-1:0];
    assign final_valid = cd_ctrl[STAGES].valid;

    // Output register and skid: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= final_valid;
            end
        end else if (final_valid && adv) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output register and skid: payload
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_angle <= r_skid_angle;
            end else begin
                r_out_angle <= final_angle;
            end
        end else if (final_valid && adv) begin
            r_skid_angle <= final_angle;
        end
    end

    assign o_valid = r_out_valid;
    assign o_angle = $signed(r_out_angle);

endmodule

`default_nettype wire

/* tb/tafa_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tafa_checker: scoreboard for the accelerometer tilt angle block
// Watches both channels, computes the angle of every accepted sample with a
// bit-exact square root and CORDIC model, and compares results in order.
// ----------------------------------------------------------------------------

module tafa_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    // sample channel
    input  wire               i_in_valid,
    input  wire               i_in_stall,
    input  wire signed [15:0] i_accel_x,
    input  wire signed [15:0] i_accel_y,
    input  wire signed [15:0] i_accel_z,
    input  wire [1:0]         i_func,
    // angle channel
    input  wire               i_out_valid,
    input  wire               i_out_stall,
    input  wire signed [14:0] i_angle,
    // status for the testbench top
    output int                o_errors,
    output int                o_pending,
    output int                o_checked
);
    import tafa_pkg::*;

    localparam int ACC_FRAC_BITS = 20;
    localparam int RND_SH        = ACC_FRAC_BITS - ANGLE_FRAC_BITS;
    localparam int CORDIC_STEPS  = 26;
    localparam int MAX_PRINTS    = 30;

    typedef logic signed [OUT_W-1:0] t_angle_out;

    // one outstanding transaction: the sample and the angle it must give
    typedef struct {
        t_sample    ax;
        t_sample    ay;
        t_sample    az;
        logic [1:0] fn;
        t_angle_out angle;
    } t_tilt_exp;

    t_tilt_exp pending_angles[$];
    int        mismatch_cnt = 0;
    int        checked_cnt  = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    // atan(2^-i) in degrees with 20 fraction bits
    function automatic longint atan_step_deg(input int idx);
        case (idx)
            0:  return 47185920;
            1:  return 27855475;
            2:  return 14718068;
            3:  return 7471121;
            4:  return 3750058;
            5:  return 1876857;
            6:  return 938658;
            7:  return 469357;
            8:  return 234682;
            9:  return 117342;
            10: return 58671;
            11: return 29335;
            12: return 14668;
            13: return 7334;
            14: return 3667;
            15: return 1833;
            16: return 917;
            17: return 458;
            18: return 229;
            19: return 115;
            20: return 57;
            21: return 29;
            22: return 14;
            23: return 7;
            24: return 4;
            25: return 2;
            default: return 0;
        endcase
    endfunction

    // floor of the square root, one result bit per pass
    function automatic longint unsigned root_floor(input longint unsigned rad);
        longint unsigned res;
        longint unsigned probe;
        res   = 0;
        probe = 64'd1 << 62;
        while (probe > rad)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rad >= res + probe) begin
                rad = rad - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    // atan2(num, sqrt(a^2 + b^2)) in 1/2^F degree, rounded and clamped
    function automatic longint tilt_deg_fixed(input longint num, input longint a,
                                              input longint b);
        longint unsigned sumsq;
        longint unsigned root;
        longint          x;
        longint          y;
        longint          z;
        longint          xs;
        longint          ys;
        longint          r;
        longint          lim;
        if (num == 0)
            return 0;
        sumsq = longint'(a * a + b * b);
        root  = root_floor(sumsq << 32);
        x     = longint'(root) <<< 14;
        y     = num <<< 30;
        z     = 0;
        // vectoring: drive y to zero, accumulate the rotation
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_step_deg(i);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_step_deg(i);
            end
        end
        r   = (z + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
        lim = 64'sd90 <<< ANGLE_FRAC_BITS;
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic t_angle_out tilt_angle(input t_sample ax, input t_sample ay,
                                              input t_sample az, input logic [1:0] fn);
        longint r;
        case (fn)
            FUNC_ROLL:  r = tilt_deg_fixed(ay, ax, az);
            FUNC_PITCH: r = tilt_deg_fixed(ax, ay, az);
            default:    r = 0;
        endcase
        return r[OUT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input t_tilt_exp e,
                                   input t_angle_out got);
        if (mismatch_cnt < MAX_PRINTS)
            $display("[%0t] MISMATCH %s: x=%0d y=%0d z=%0d func=%0d angle=%0d exp=%0d",
                     $time, what, e.ax, e.ay, e.az, e.fn, got, e.angle);
        mismatch_cnt++;
    endtask

    // result side first; an angle can never come from the same-cycle sample
    always @(posedge i_clk) begin : watch
        t_tilt_exp e;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_angles.size() == 0) begin
                    e = '{default: '0};
                    report_mismatch("angle with no transaction outstanding", e, i_angle);
                end else begin
                    e = pending_angles.pop_front();
                    checked_cnt++;
                    if (i_angle !== e.angle)
                        report_mismatch("wrong angle", e, i_angle);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                e.ax    = i_accel_x;
                e.ay    = i_accel_y;
                e.az    = i_accel_z;
                e.fn    = i_func;
                e.angle = tilt_angle(i_accel_x, i_accel_y, i_accel_z, i_func);
                pending_angles.push_back(e);
            end
        end
        o_pending <= pending_angles.size();
        o_errors  <= mismatch_cnt;
        o_checked <= checked_cnt;
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top for tilt_angle_from_accel
// Drives directed corner samples and then randomized sensor vectors with
// bursty idle and backpressure, and reports the scoreboard verdict.
// ----------------------------------------------------------------------------

module tb;
    import tafa_pkg::*;

    localparam int          LIMIT_CYCLES  = 200000;
    localparam int          RANDOM_ITEMS  = 1200;
    localparam int          SEG_ITEMS     = 100;
    localparam int          CALM_SEGS     = 2;
    localparam int          TAIL_CYCLES   = 80;
    localparam logic [1:0]  FUNC_SPARE_2  = 2'd2;
    localparam logic [1:0]  FUNC_SPARE_3  = 2'd3;
    localparam logic signed [15:0] S_MAX  = 16'sh7FFF;
    localparam logic signed [15:0] S_MIN  = -16'sh8000;

    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   i_valid   = 1'b0;
    logic signed [15:0]     i_accel_x = '0;
    logic signed [15:0]     i_accel_y = '0;
    logic signed [15:0]     i_accel_z = '0;
    logic [1:0]             i_func    = FUNC_ROLL;
    logic                   i_stall   = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic signed [OUT_W-1:0] o_angle;

    int chk_errors;
    int chk_pending;
    int chk_checked;

    // stimulus bookkeeping
    bit stall_on  = 1'b1;
    int stall_left = 0;
    int cycle_cnt = 0;
    int sent_roll = 0;
    int sent_pitch = 0;
    int sent_spare = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    tilt_angle_from_accel u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_accel_x (i_accel_x),
        .i_accel_y (i_accel_y),
        .i_accel_z (i_accel_z),
        .i_func    (i_func),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_angle   (o_angle)
    );

    tafa_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .i_accel_z   (i_accel_z),
        .i_func      (i_func),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_angle     (o_angle),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending),
        .o_checked   (chk_checked)
    );

    // runaway guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d angles outstanding",
                     cycle_cnt, chk_pending);
            $display("Verification failed");
            $finish;
        end
    end

    // output backpressure in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || !stall_on) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_stall    <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end else begin
            i_stall    <= 1'b0;
        end
    end

    // one sample transaction, optionally preceded by an idle burst
    task automatic send_sample(input t_sample ax, input t_sample ay, input t_sample az,
                               input logic [1:0] fn, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_accel_x <= ax;
        i_accel_y <= ay;
        i_accel_z <= az;
        i_func    <= fn;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        case (fn)
            FUNC_ROLL:  sent_roll++;
            FUNC_PITCH: sent_pitch++;
            default:    sent_spare++;
        endcase
    endtask

    // mix of full-range, near-zero, gravity-scale and extreme readings
    function automatic t_sample rand_sample();
        int mode;
        int mag;
        mode = $urandom_range(0, 9);
        if (mode <= 3)
            return t_sample'($urandom);
        if (mode <= 5) begin
            mag = $urandom_range(0, 64);
            return t_sample'($urandom_range(0, 1) ? -mag : mag);
        end
        if (mode <= 7) begin
            mag = $urandom_range(12000, 20000);
            return t_sample'($urandom_range(0, 1) ? -mag : mag);
        end
        if (mode == 8) begin
            case ($urandom_range(0, 4))
                0:       return S_MAX;
                1:       return S_MIN;
                2:       return 16'sd1;
                3:       return -16'sd1;
                default: return 16'sd0;
            endcase
        end
        return '0;
    endfunction

    function automatic logic [1:0] rand_func();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 3)
            return FUNC_ROLL;
        if (pick <= 7)
            return FUNC_PITCH;
        if (pick == 8)
            return FUNC_SPARE_2;
        return FUNC_SPARE_3;
    endfunction

    initial begin
        bit idle_ok;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero vector, zero numerator, spare selectors
        send_sample(16'sd0, 16'sd0, 16'sd0, FUNC_ROLL, 1'b1);
        send_sample(16'sd0, 16'sd0, 16'sd0, FUNC_PITCH, 1'b1);
        send_sample(16'sd0, 16'sd0, 16'sd0, FUNC_SPARE_2, 1'b1);
        send_sample(16'sd0, 16'sd0, 16'sd0, FUNC_SPARE_3, 1'b1);
        send_sample(16'sd5000, 16'sd0, 16'sd16384, FUNC_ROLL, 1'b1);
        send_sample(16'sd0, -16'sd7000, 16'sd16384, FUNC_PITCH, 1'b1);
        send_sample(S_MAX, S_MIN, S_MAX, FUNC_SPARE_2, 1'b1);
        send_sample(S_MIN, S_MAX, S_MIN, FUNC_SPARE_3, 1'b1);
        // directed: straight up and down, where the clamp to 90 degrees applies
        send_sample(16'sd0, 16'sd1, 16'sd0, FUNC_ROLL, 1'b1);
        send_sample(-16'sd1, 16'sd0, 16'sd0, FUNC_PITCH, 1'b1);
        send_sample(16'sd0, S_MAX, 16'sd0, FUNC_ROLL, 1'b1);
        send_sample(16'sd0, S_MIN, 16'sd0, FUNC_ROLL, 1'b1);
        send_sample(S_MAX, 16'sd0, 16'sd0, FUNC_PITCH, 1'b1);
        send_sample(S_MIN, 16'sd0, 16'sd0, FUNC_PITCH, 1'b1);
        // directed: full-scale corners
        send_sample(S_MIN, S_MIN, S_MIN, FUNC_ROLL, 1'b1);
        send_sample(S_MIN, S_MIN, S_MIN, FUNC_PITCH, 1'b1);
        send_sample(S_MAX, S_MAX, S_MAX, FUNC_ROLL, 1'b1);
        send_sample(S_MAX, S_MAX, S_MAX, FUNC_PITCH, 1'b1);
        send_sample(S_MAX, S_MIN, 16'sd0, FUNC_ROLL, 1'b1);
        send_sample(S_MIN, S_MAX, 16'sd0, FUNC_PITCH, 1'b1);
        // directed: tiny numerator against a huge denominator and level sensor
        send_sample(S_MIN, 16'sd1, S_MIN, FUNC_ROLL, 1'b1);
        send_sample(-16'sd1, S_MAX, S_MAX, FUNC_PITCH, 1'b1);
        send_sample(16'sd0, 16'sd0, 16'sd16384, FUNC_ROLL, 1'b1);
        send_sample(16'sd11585, 16'sd0, 16'sd11585, FUNC_PITCH, 1'b1);

        // random segments; idling varies per segment and stops at the end
        for (int seg = 0; seg < RANDOM_ITEMS / SEG_ITEMS; seg++) begin
            if (seg >= RANDOM_ITEMS / SEG_ITEMS - CALM_SEGS) begin
                idle_ok = 1'b0;
                stall_on <= 1'b0;
            end else begin
                idle_ok = ($urandom_range(0, 3) != 0);
                stall_on <= ($urandom_range(0, 3) != 0);
            end
            for (int n = 0; n < SEG_ITEMS; n++)
                send_sample(rand_sample(), rand_sample(), rand_sample(), rand_func(),
                            idle_ok);
        end
        i_valid <= 1'b0;

        // drain, then give stray results time to show up
        @(posedge i_clk);
        while (chk_pending != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d samples: %0d roll, %0d pitch, %0d spare selector",
                 sent_roll + sent_pitch + sent_spare, sent_roll, sent_pitch, sent_spare);
        $display("Checked %0d angles, %0d mismatches", chk_checked, chk_errors);
        if (chk_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
design/tafa_pkg.sv
design/tafa_sqrt_cell.sv
design/tafa_cordic_cell.sv
design/tilt_angle_from_accel.sv
tb/tafa_checker.sv
tb/tb.sv
